>>> rtl/assert_macros.svh
// Assertion macros for the sentence checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/nsc_pkg.sv
// Types, constants and helper functions of the sentence checker.
package nsc_pkg;

    localparam int MAX_SENTENCE = 128;
    localparam int MAX_FIELDS   = 32;
    localparam int TOKEN_LEN    = 6;
    localparam int NUM_TYPES    = 5;

    localparam logic [6:0] BYTE_MAX  = 7'(MAX_SENTENCE - 1);
    localparam logic [4:0] FIELD_MAX = 5'(MAX_FIELDS - 1);
    localparam logic [6:0] CHARS_MAX = 7'd127;
    localparam logic [6:0] TOKEN_CHARS = 7'(TOKEN_LEN);

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    // Type tokens, one row per recognized sentence type
    localparam logic [7:0] TYPE_NAMES [NUM_TYPES][TOKEN_LEN] = '{
        '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // $GPRMC
        '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47},  // $GPVTG
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // $GPGGA
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // $GPGSA
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56}   // $GPGSV
    };

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_END     = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TYPE_OTHER = 3'd0,
        TYPE_RMC   = 3'd1,
        TYPE_VTG   = 3'd2,
        TYPE_GGA   = 3'd3,
        TYPE_GSA   = 3'd4,
        TYPE_GSV   = 3'd5
    } t_stype;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_NO_STAR  = 2'd2,
        VERDICT_OVERLONG = 2'd3
    } t_verdict;

    // One output word
    typedef struct packed {
        t_kind       kind;
        t_stype      stype;
        logic [4:0]  field_index;
        logic [7:0]  field_char;
        logic [6:0]  field_length;
        t_verdict    verdict;
        logic [7:0]  rx_sum;
        logic [7:0]  calc_sum;
    } t_result;

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    // Lowest surviving candidate wins; unknown until the type token has ended
    function automatic t_stype cur_type(input logic done, input logic [NUM_TYPES-1:0] match);
        t_stype t;
        t = TYPE_OTHER;
        for (int k = NUM_TYPES - 1; k >= 0; k--) begin
            if (match[k]) t = t_stype'(3'(k + 1));
        end
        if (!done) t = TYPE_OTHER;
        return t;
    endfunction

endpackage

>>> rtl/nsc_in_stage.sv
// Input register for received bytes.
module nsc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Refill whenever empty or being drained this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

>>> rtl/nsc_parser.sv
// Per-byte sentence state: checksum, type match, field tracking and verdict.
module nsc_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_res_valid,
    output nsc_pkg::t_result   o_res
);

    logic [6:0]                    r_byte_count, n_byte_count;
    logic [7:0]                    r_xor, n_xor;
    logic                          r_star, n_star;
    logic [4:0]                    r_field_number, n_field_number;
    logic [6:0]                    r_field_chars, n_field_chars;
    logic [nsc_pkg::NUM_TYPES-1:0] r_type_match, n_type_match;
    logic                          r_first_done, n_first_done;
    logic [2:0][7:0]               r_recent, n_recent;
    logic                          r_overlong, n_overlong;

    logic [nsc_pkg::NUM_TYPES-1:0] match_c;
    nsc_pkg::t_stype               stype_c;
    logic [7:0]                    rx_c;
    nsc_pkg::t_result              res;
    logic                          has_res;

    assign o_take = i_valid && i_out_free;
    assign rx_c   = {nsc_pkg::hex_nibble(r_recent[2]), nsc_pkg::hex_nibble(r_recent[1])};

    // Next state and result for the byte in the input register
    always_comb begin
        n_byte_count   = r_byte_count;
        n_xor          = r_xor;
        n_star         = r_star;
        n_field_number = r_field_number;
        n_field_chars  = r_field_chars;
        n_type_match   = r_type_match;
        n_first_done   = r_first_done;
        n_recent       = r_recent;
        n_overlong     = r_overlong;
        match_c        = r_type_match;
        stype_c        = nsc_pkg::cur_type(r_first_done, r_type_match);
        res            = '0;
        has_res        = 1'b0;

        if (i_byte == nsc_pkg::CHAR_LF) begin
            // End of sentence: verdict, then back to the idle sentence state
            res.kind     = nsc_pkg::KIND_VERDICT;
            res.stype    = stype_c;
            res.rx_sum   = rx_c;
            res.calc_sum = r_xor;
            if (r_overlong) res.verdict = nsc_pkg::VERDICT_OVERLONG;
            else if (!r_star) res.verdict = nsc_pkg::VERDICT_NO_STAR;
            else if (rx_c != r_xor) res.verdict = nsc_pkg::VERDICT_MISMATCH;
            else res.verdict = nsc_pkg::VERDICT_OK;
            has_res        = 1'b1;
            n_byte_count   = '0;
            n_xor          = '0;
            n_star         = 1'b0;
            n_field_number = '0;
            n_field_chars  = '0;
            n_type_match   = '1;
            n_first_done   = 1'b0;
            n_recent       = '0;
            n_overlong     = 1'b0;
        end else begin
            // Length with saturation
            if (r_byte_count >= nsc_pkg::BYTE_MAX) n_overlong = 1'b1;
            else n_byte_count = r_byte_count + 7'd1;

            n_recent[2] = r_recent[1];
            n_recent[1] = r_recent[0];
            n_recent[0] = i_byte;

            // Checksum runs up to the star, skipping '$'
            if (!r_star) begin
                if (i_byte == nsc_pkg::CHAR_STAR) n_star = 1'b1;
                else if (i_byte != nsc_pkg::CHAR_DOLLAR) n_xor = r_xor ^ i_byte;
            end

            if (!r_star) begin
                if (!r_first_done) begin
                    if (i_byte == nsc_pkg::CHAR_COMMA) begin
                        // Type token closes: needs exactly six matching chars
                        if (r_field_chars != nsc_pkg::TOKEN_CHARS) match_c = '0;
                        n_type_match = match_c;
                        n_first_done = 1'b1;
                        stype_c      = nsc_pkg::cur_type(1'b1, match_c);
                        if (stype_c != nsc_pkg::TYPE_OTHER) begin
                            res.kind         = nsc_pkg::KIND_END;
                            res.stype        = stype_c;
                            res.field_index  = r_field_number;
                            res.field_length = r_field_chars;
                            has_res          = 1'b1;
                        end
                        if (r_field_number < nsc_pkg::FIELD_MAX) begin
                            n_field_number = r_field_number + 5'd1;
                        end
                        n_field_chars = '0;
                    end else begin
                        // Knock out candidates that differ at this position
                        if (r_field_chars < nsc_pkg::TOKEN_CHARS) begin
                            for (int k = 0; k < nsc_pkg::NUM_TYPES; k++) begin
                                if (nsc_pkg::TYPE_NAMES[k][r_field_chars[2:0]] != i_byte) begin
                                    n_type_match[k] = 1'b0;
                                end
                            end
                        end else begin
                            n_type_match = '0;
                        end
                        if (r_field_chars < nsc_pkg::CHARS_MAX) begin
                            n_field_chars = r_field_chars + 7'd1;
                        end
                    end
                end else if (stype_c != nsc_pkg::TYPE_OTHER) begin
                    // Field stream of a recognized sentence
                    res.stype       = stype_c;
                    res.field_index = r_field_number;
                    has_res         = 1'b1;
                    if (i_byte == nsc_pkg::CHAR_COMMA || i_byte == nsc_pkg::CHAR_STAR) begin
                        res.kind         = nsc_pkg::KIND_END;
                        res.field_length = r_field_chars;
                        if (r_field_number < nsc_pkg::FIELD_MAX) begin
                            n_field_number = r_field_number + 5'd1;
                        end
                        n_field_chars = '0;
                    end else begin
                        res.kind       = nsc_pkg::KIND_CHAR;
                        res.field_char = i_byte;
                        if (r_field_chars < nsc_pkg::CHARS_MAX) begin
                            n_field_chars = r_field_chars + 7'd1;
                        end
                    end
                end
            end
        end
    end

    // Sentence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_xor          <= '0;
            r_star         <= 1'b0;
            r_field_number <= '0;
            r_field_chars  <= '0;
            r_type_match   <= '1;
            r_first_done   <= 1'b0;
            r_recent       <= '0;
            r_overlong     <= 1'b0;
        end else if (o_take) begin
            r_byte_count   <= n_byte_count;
            r_xor          <= n_xor;
            r_star         <= n_star;
            r_field_number <= n_field_number;
            r_field_chars  <= n_field_chars;
            r_type_match   <= n_type_match;
            r_first_done   <= n_first_done;
            r_recent       <= n_recent;
            r_overlong     <= n_overlong;
        end
    end

    assign o_res_valid = o_take && has_res;
    assign o_res       = res;

endmodule

>>> rtl/nsc_out_stage.sv
// Output register holding one result word until the consumer takes it.
module nsc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nsc_pkg::t_result   i_res,
    input  logic               i_tready,
    output logic               o_free,
    output logic               o_tvalid,
    output nsc_pkg::t_result   o_res
);

    logic             r_valid;
    nsc_pkg::t_result r_res;

    // Free when empty or the held word leaves this cycle
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule

>>> rtl/nmea_sentence_checker.sv
// A byte waits in the input register while the combinational parsing logic forms its word,
// if any; the word is loaded into the output register when that register is free.
// Throughput: one byte per cycle, sustained, while the output side keeps taking words.
// Reset (i_rst_n low, synchronous) empties both registers and returns the sentence
// state to the start of a sentence; no clearing pass is needed.
`include "assert_macros.svh"

// Top level of the sentence checker.
module nmea_sentence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] sentence_type, [7:3] field_index, [15:8] field_char, [22:16] field_length,
    // [24:23] verdict, [32:25] received_checksum, [40:33] computed_checksum, [47:41] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] item_kind
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             take;
    logic             out_free;
    logic             res_valid;
    nsc_pkg::t_result res;
    nsc_pkg::t_result out_res;

    nsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_take  (take),
        .o_ready (s_axis_tready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    nsc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .i_tready (m_axis_tready),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .o_res    (out_res)
    );

    // Pack the result word
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {7'd0, out_res.calc_sum, out_res.rx_sum, out_res.verdict,
                           out_res.field_length, out_res.field_char,
                           out_res.field_index, out_res.stype};

    // Checks
    `NSC_ASSERT_NOW(a_verdict_clean, m_axis_tvalid && out_res.kind == nsc_pkg::KIND_VERDICT, out_res.field_index == 5'd0 && out_res.field_char == 8'd0, "verdict word carries field data")
    `NSC_ASSERT_NOW(a_field_typed, m_axis_tvalid && out_res.kind != nsc_pkg::KIND_VERDICT, out_res.stype != nsc_pkg::TYPE_OTHER, "field word for unrecognized sentence")
    `NSC_ASSERT_NOW(a_char_no_len, m_axis_tvalid && out_res.kind == nsc_pkg::KIND_CHAR, out_res.field_length == 7'd0 && out_res.verdict == nsc_pkg::VERDICT_OK, "char word carries length or verdict")
    `NSC_ASSERT_NEXT(a_in_hold, in_valid && !take, in_valid && $stable(in_byte), "input register lost a pending byte")

endmodule

>>> bench/tb_nmea_sentence_checker.sv
`timescale 1ns / 1ps
// Testbench for the NMEA sentence checker: drives a byte stream and checks every output word.
module tb_nmea_sentence_checker;
    import nsc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] sentence_type, [7:3] field_index, [15:8] field_char, [22:16] field_length,
    // [24:23] verdict, [32:25] received_checksum, [40:33] computed_checksum, [47:41] zero
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // [1:0] item_kind

    nmea_sentence_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Pending bytes, sentence under construction, words still owed by the block
    logic [7:0] tx_bytes [$];
    logic [7:0] body_q [$];
    t_result    expected_words [$];

    int   total_bytes = 0;
    int   bytes_in = 0;
    int   words_out = 0;
    int   errors = 0;
    int   verdict_tally [4] = '{0, 0, 0, 0};
    logic in_fire = 1'b0;

    // Mirror of the parser state
    logic [6:0]           n_bytes;
    logic [7:0]           running_xor;
    logic                 star_found;
    logic [4:0]           field_no;
    logic [6:0]           field_len;
    logic [NUM_TYPES-1:0] candidates;
    logic                 token_ended;
    logic [7:0]           tail [3];
    logic                 too_long;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= "0" && c <= "9") n = c[3:0];
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) n = 4'(c[3:0] + 4'd9);
        return n;
    endfunction

    // First surviving candidate, once the type token is closed
    function automatic t_stype decoded_type();
        t_stype t;
        t = TYPE_OTHER;
        if (token_ended) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
                if (candidates[k] && t == TYPE_OTHER) t = t_stype'(3'(k + 1));
            end
        end
        return t;
    endfunction

    task automatic clear_sentence_state();
        n_bytes = '0;
        running_xor = '0;
        star_found = 1'b0;
        field_no = '0;
        field_len = '0;
        candidates = '1;
        token_ended = 1'b0;
        tail = '{8'h00, 8'h00, 8'h00};
        too_long = 1'b0;
    endtask

    task automatic next_field();
        if (field_no < FIELD_MAX) field_no++;
        field_len = '0;
    endtask

    task automatic count_char();
        if (field_len < CHARS_MAX) field_len++;
    endtask

    task automatic owe_word(input t_kind kind, input t_stype st, input logic [4:0] idx,
                            input logic [7:0] ch, input logic [6:0] len, input t_verdict v,
                            input logic [7:0] rx, input logic [7:0] calc);
        t_result w;
        w = '0;
        w.kind = kind;
        w.stype = st;
        w.field_index = idx;
        w.field_char = ch;
        w.field_length = len;
        w.verdict = v;
        w.rx_sum = rx;
        w.calc_sum = calc;
        expected_words.push_back(w);
    endtask

    // Advance the mirror by one accepted byte and queue the word it causes
    task automatic parse_byte(input logic [7:0] ch);
        logic [7:0] rx;
        t_verdict   v;
        logic       was_star;
        t_stype     t;
        if (ch == CHAR_LF) begin
            rx = {nibble_of(tail[2]), nibble_of(tail[1])};
            if (too_long) v = VERDICT_OVERLONG;
            else if (!star_found) v = VERDICT_NO_STAR;
            else if (rx != running_xor) v = VERDICT_MISMATCH;
            else v = VERDICT_OK;
            owe_word(KIND_VERDICT, decoded_type(), '0, '0, '0, v, rx, running_xor);
            clear_sentence_state();
            return;
        end

        if (n_bytes >= BYTE_MAX) too_long = 1'b1;
        else n_bytes++;
        tail[2] = tail[1];
        tail[1] = tail[0];
        tail[0] = ch;

        was_star = star_found;
        if (!star_found) begin
            if (ch == CHAR_STAR) star_found = 1'b1;
            else if (ch != CHAR_DOLLAR) running_xor ^= ch;
        end
        if (was_star) return;

        // Type token: narrow the candidate set one character at a time
        if (!token_ended) begin
            if (ch == CHAR_COMMA) begin
                if (field_len != TOKEN_CHARS) candidates = '0;
                token_ended = 1'b1;
                t = decoded_type();
                if (t != TYPE_OTHER)
                    owe_word(KIND_END, t, field_no, '0, field_len, VERDICT_OK, '0, '0);
                next_field();
            end else begin
                if (field_len < TOKEN_CHARS) begin
                    for (int k = 0; k < NUM_TYPES; k++) begin
                        if (TYPE_NAMES[k][field_len] != ch) candidates[k] = 1'b0;
                    end
                end else begin
                    candidates = '0;
                end
                count_char();
            end
            return;
        end

        t = decoded_type();
        if (t == TYPE_OTHER) return;
        if (ch == CHAR_COMMA || ch == CHAR_STAR) begin
            owe_word(KIND_END, t, field_no, '0, field_len, VERDICT_OK, '0, '0);
            next_field();
        end else begin
            owe_word(KIND_CHAR, t, field_no, ch, '0, VERDICT_OK, '0, '0);
            count_char();
        end
    endtask

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic check_word();
        t_result w;
        words_out++;
        if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d data %h", m_axis_tuser, m_axis_tdata);
            errors++;
            return;
        end
        w = expected_words.pop_front();
        compare_field("item_kind", w.kind, m_axis_tuser);
        compare_field("sentence_type", w.stype, m_axis_tdata[2:0]);
        compare_field("field_index", w.field_index, m_axis_tdata[7:3]);
        compare_field("field_char", w.field_char, m_axis_tdata[15:8]);
        compare_field("field_length", w.field_length, m_axis_tdata[22:16]);
        compare_field("verdict", w.verdict, m_axis_tdata[24:23]);
        compare_field("received_checksum", w.rx_sum, m_axis_tdata[32:25]);
        compare_field("computed_checksum", w.calc_sum, m_axis_tdata[40:33]);
        compare_field("tdata padding", 0, m_axis_tdata[47:41]);
        if (w.kind == KIND_VERDICT) verdict_tally[w.verdict]++;
    endtask

    // Stall pattern: three phases over the run, keyed on how far the input has got
    function automatic bit idle_now(input bit sender);
        int phase;
        int pct;
        phase = (total_bytes == 0) ? 0 : (bytes_in * 3) / total_bytes;
        case (phase)
            0: pct = sender ? 15 : 54;
            1: pct = sender ? 54 : 15;
            default: pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            parse_byte(s_axis_tdata);
            bytes_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
    end

    // Drive both sides at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || in_fire) begin
                if (tx_bytes.size() != 0 && !idle_now(1'b1)) begin
                    s_axis_tdata <= tx_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !idle_now(1'b0);
        end
    end

    // Sentence building
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endtask

    task automatic commit();
        foreach (body_q[i]) tx_bytes.push_back(body_q[i]);
        body_q.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    // Printable field character, never a delimiter; a dollar now and then
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0) return CHAR_DOLLAR;
        do c = 8'($urandom_range(32, 126)); while (c == CHAR_COMMA || c == CHAR_STAR);
        return c;
    endfunction

    // Close the body with star, hex checksum, CR and LF
    task automatic close_checked(input bit corrupt, input bit lower);
        logic [7:0] sum;
        sum = '0;
        foreach (body_q[i]) if (body_q[i] != CHAR_DOLLAR) sum ^= body_q[i];
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        body_q.push_back(CHAR_STAR);
        body_q.push_back(hex_char(sum[7:4], lower));
        body_q.push_back(hex_char(sum[3:0], lower));
        body_q.push_back(8'h0D);
        body_q.push_back(CHAR_LF);
        commit();
    endtask

    task automatic gen_sentence();
        int mode;
        int nf;
        int len;
        int k;
        mode = $urandom_range(0, 99);
        // Raw noise, any byte value
        if (mode < 8) begin
            len = $urandom_range(0, 12);
            repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
            body_q.push_back(CHAR_LF);
            commit();
            return;
        end

        // Type token: mostly a real one, else a near miss or junk
        k = $urandom_range(0, NUM_TYPES - 1);
        if ($urandom_range(0, 99) < 80) begin
            for (int i = 0; i < TOKEN_LEN; i++) body_q.push_back(TYPE_NAMES[k][i]);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    len = $urandom_range(4, 8);
                    repeat (len) body_q.push_back(field_char());
                end
                1: for (int i = 0; i < TOKEN_LEN - 1; i++) body_q.push_back(TYPE_NAMES[k][i]);
                default: begin
                    for (int i = 0; i < TOKEN_LEN; i++) body_q.push_back(TYPE_NAMES[k][i]);
                    body_q.push_back(field_char());
                end
            endcase
        end

        // Token closed by the star or the line feed instead of a comma
        if (mode < 14) begin
            if (mode < 11) begin
                close_checked(1'b0, 1'($urandom_range(0, 1)));
            end else begin
                body_q.push_back(CHAR_LF);
                commit();
            end
            return;
        end

        // One very long field: runs past the sentence limit
        if (mode < 20) begin
            body_q.push_back(CHAR_COMMA);
            len = $urandom_range(118, 180);
            repeat (len) body_q.push_back(field_char());
            close_checked($urandom_range(0, 3) == 0, 1'b0);
            return;
        end

        // Regular fields; now and then enough to saturate the field index
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        repeat (nf) begin
            body_q.push_back(CHAR_COMMA);
            len = (nf >= 30) ? $urandom_range(0, 1) : $urandom_range(0, 5);
            repeat (len) body_q.push_back(field_char());
        end
        if (mode < 28) begin
            body_q.push_back(8'h0D);
            body_q.push_back(CHAR_LF);
            commit();
            return;
        end
        close_checked($urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
    endtask

    // Stimulus, reset and end of run
    initial begin
        clear_sentence_state();

        // Directed: empty sentence, byte extremes, dollar inside a field, bad hex digit
        tx_bytes.push_back(CHAR_LF);
        body_q = '{8'h00, 8'hFF, CHAR_LF};
        commit();
        add_text("$GPVTG,$");
        close_checked(1'b0, 1'b0);
        add_text("A*0g");
        body_q.push_back(8'h0D);
        body_q.push_back(CHAR_LF);
        commit();

        while (tx_bytes.size() < 620) gen_sentence();
        total_bytes = tx_bytes.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (bytes_in < total_bytes || expected_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d bytes in random-length sentences; checked %0d output words.",
                 bytes_in, words_out);
        $display("Verdicts seen: %0d ok, %0d mismatch, %0d no star, %0d overlong.",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout waiting for the block to drain");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> nmea_sentence_checker.f
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_in_stage.sv
rtl/nsc_parser.sv
rtl/nsc_out_stage.sv
rtl/nmea_sentence_checker.sv
bench/tb_nmea_sentence_checker.sv
